/* design/fpp_pkg.sv */
// Shared types and constants of the front-end packet parser.
package fpp_pkg;

  typedef enum logic [2:0] {
    PH_HUNT    = 3'd0,
    PH_HEADER  = 3'd1,
    PH_COUNT   = 3'd2,
    PH_START   = 3'd3,
    PH_SAMPLES = 3'd4,
    PH_SKIP    = 3'd5
  } phase_t;

  localparam logic [1:0] REG_MAGIC_ONE = 2'd0;
  localparam logic [1:0] REG_MAGIC_TWO = 2'd1;
  localparam logic [1:0] REG_HEADER    = 2'd2;
  localparam logic [1:0] REG_FEE       = 2'd3;

  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_CRC    = 2'd1;
  localparam logic [1:0] ST_FORMAT = 2'd2;

  localparam logic [15:0] CRC_INIT = 16'hffff;
  localparam logic [15:0] CRC_POLY = 16'h8005;
  localparam logic [3:0]  MIN_HEADER = 4'd7;

  typedef struct packed {
    logic        kind;
    logic [8:0]  channel;
    logic [19:0] crossing_time;
    logic [10:0] time_bin;
    logic [15:0] adc_value;
    logic [1:0]  status;
  } rec_t;

  function automatic logic [15:0] crc_word(input logic [15:0] crc, input logic [15:0] w);
    logic [15:0] c;
    c = crc ^ w;
    for (int k = 0; k < 16; k++) begin
      c = c[15] ? ((c << 1) ^ CRC_POLY) : (c << 1);
    end
    return c;
  endfunction

endpackage

/* design/fpp_front.sv */
// Front part: window hunt, header capture, CRC and group tracking, one word a beat.
module fpp_front
  import fpp_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_beat,
  input  logic [15:0] word,
  input  logic [15:0] magic_one,
  input  logic [15:0] magic_two,
  input  logic [3:0]  header_words,
  output logic        rec_valid,
  output rec_t        rec
);

  phase_t      phase, phase_next;
  logic [15:0] win0, win1, win2;
  logic [1:0]  fill;
  logic [15:0] pos, len, crc, left;
  logic [8:0]  chan;
  logic [9:0]  t_lo, t_hi;
  logic [10:0] tbin;
  logic        err;

  logic [15:0] hlen;
  logic [15:0] n0, n1, n2;
  logic        full, hit;
  logic [16:0] p1, p2, pls;
  logic        last;
  logic [15:0] crc_hit;
  logic [8:0]  chan_v;
  logic [9:0]  lo_v, hi_v;

  assign hlen = {12'd0, (header_words < MIN_HEADER) ? MIN_HEADER : header_words};
  assign full = (fill == 2'd3);
  assign n0   = full ? win1 : (fill == 2'd0 ? word : win0);
  assign n1   = full ? win2 : (fill == 2'd1 ? word : win1);
  assign n2   = (full || fill == 2'd2) ? word : win2;
  assign hit  = (fill >= 2'd2) && n1 == magic_one && n2 == magic_two;
  assign p1   = {1'b0, pos} + 17'd1;
  assign p2   = {1'b0, pos} + 17'd2;
  assign pls  = p1 + {1'b0, left};
  assign last = p1 >= {1'b0, len};
  assign crc_hit = crc_word(crc_word(crc_word(CRC_INIT, n0), n1), n2);
  assign chan_v = (pos == 16'd4) ? word[8:0] : chan;
  assign lo_v   = (pos == 16'd5) ? word[9:0] : t_lo;
  assign hi_v   = (pos == 16'd6) ? word[9:0] : t_hi;

  always_comb begin
    phase_next = phase;
    case (phase)
      PH_HUNT:    if (hit && n0 >= hlen) phase_next = PH_HEADER;
      PH_HEADER:  if (last) phase_next = PH_HUNT;
                  else if (p1 >= {1'b0, hlen}) phase_next = PH_COUNT;
      PH_COUNT:   phase_next = last ? PH_HUNT : PH_START;
      PH_START:   if (last) phase_next = PH_HUNT;
                  else if (pls >= {1'b0, len}) phase_next = PH_SKIP;
                  else if (left == 16'd0) phase_next = (p2 == {1'b0, len}) ? PH_SKIP : PH_COUNT;
                  else phase_next = PH_SAMPLES;
      PH_SAMPLES: if (last) phase_next = PH_HUNT;
                  else if (p2 == {1'b0, len}) phase_next = PH_SKIP;
                  else if (left == 16'd1) phase_next = PH_COUNT;
      PH_SKIP:    if (last) phase_next = PH_HUNT;
      default:    phase_next = PH_HUNT;
    endcase
  end

  always_comb begin
    rec_valid = 1'b0;
    rec = '0;
    if (phase == PH_HUNT) begin
      if (hit && n0 < hlen) begin
        rec_valid = in_beat;
        rec.kind = 1'b1;
        rec.status = ST_FORMAT;
      end
    end else if (last) begin
      rec_valid = in_beat;
      rec.kind = 1'b1;
      rec.channel = chan_v;
      rec.crossing_time = {hi_v, lo_v};
      if (crc != word) rec.status = ST_CRC;
      else if (err || phase == PH_COUNT || phase == PH_START) rec.status = ST_FORMAT;
      else rec.status = ST_OK;
    end else if (phase == PH_SAMPLES) begin
      rec_valid = in_beat;
      rec.channel = chan_v;
      rec.crossing_time = {hi_v, lo_v};
      rec.time_bin = tbin;
      rec.adc_value = word;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_HUNT;
      fill <= 2'd0;
      win0 <= '0; win1 <= '0; win2 <= '0;
      pos <= '0; len <= '0; crc <= CRC_INIT; left <= '0;
      chan <= '0; t_lo <= '0; t_hi <= '0; tbin <= '0; err <= 1'b0;
    end else if (in_beat) begin
      phase <= phase_next;
      if (phase == PH_HUNT) begin
        if (!hit) begin
          win0 <= n0; win1 <= n1; win2 <= n2;
          fill <= full ? 2'd3 : fill + 2'd1;
        end else if (n0 < hlen) begin
          win0 <= n1; win1 <= n2; win2 <= '0;
          fill <= 2'd2;
        end else begin
          win0 <= n0; win1 <= n1; win2 <= n2;
          fill <= 2'd0;
          len <= n0;
          crc <= crc_hit;
          pos <= 16'd3;
          chan <= '0; t_lo <= '0; t_hi <= '0;
          err <= 1'b0; left <= '0; tbin <= '0;
        end
      end else begin
        chan <= chan_v; t_lo <= lo_v; t_hi <= hi_v;
        if (last) begin
          fill <= 2'd0;
          pos <= '0;
        end else begin
          crc <= crc_word(crc, word);
          pos <= p1[15:0];
          case (phase)
            PH_COUNT: left <= word;
            PH_START: begin
              if (pls >= {1'b0, len}) err <= 1'b1;
              else if (left != 16'd0) tbin <= word[10:0];
            end
            PH_SAMPLES: begin
              left <= left - 16'd1;
              tbin <= tbin + 11'd1;
            end
            default: ;
          endcase
        end
      end
    end
  end

  property p_len_held;
    @(posedge clk) disable iff (rst)
      (phase != PH_HUNT && $past(phase) != PH_HUNT) |-> $stable(len);
  endproperty
  a_len_held: assert property (p_len_held) else $error("length changed mid packet");

  a_fill_range: assert property (@(posedge clk) disable iff (rst)
    fill != 2'd3 || phase == PH_HUNT) else $error("window full outside hunt");

  a_end_rec: assert property (@(posedge clk) disable iff (rst)
    (rec_valid && phase != PH_HUNT && !last) |-> (phase == PH_SAMPLES && !rec.kind))
    else $error("record outside samples");

endmodule

/* design/fpp_queue.sv */
// Two-entry queue between the front part and the output stage.
module fpp_queue
  import fpp_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  rec_t push_rec,
  output logic room,
  output logic pop_valid,
  output rec_t pop_rec,
  input  logic pop
);

  rec_t mem [2];
  logic       wp, rp;
  logic [1:0] cnt;

  assign room = cnt != 2'd2;
  assign pop_valid = cnt != 2'd0;
  assign pop_rec = mem[rp];

  always_ff @(posedge clk) begin
    if (push) mem[wp] <= push_rec;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= 1'b0; rp <= 1'b0; cnt <= 2'd0;
    end else begin
      if (push) wp <= ~wp;
      if (pop) rp <= ~rp;
      cnt <= cnt + {1'b0, push} - {1'b0, pop};
    end
  end

  a_no_over: assert property (@(posedge clk) disable iff (rst) push |-> room)
    else $error("queue overflow");
  a_no_under: assert property (@(posedge clk) disable iff (rst) pop |-> pop_valid)
    else $error("queue underflow");
  a_cnt: assert property (@(posedge clk) disable iff (rst) cnt != 2'd3)
    else $error("bad count");

endmodule

/* design/fee_packet_parser.sv */
// Top level of the front-end packet parser.
// Input channel: one 16-bit stream word per beat on data_word (data_valid/data_stall).
// Output channel: one record per beat (out_valid/out_stall): sample records
// for each payload sample, one end record per packet with its status.
// Configuration: cfg_write, cfg_index, cfg_data; write only while idle.
// A word is taken every cycle while the queue has room; the front part handles
// each word in the cycle it is accepted, and its record is registered into a
// two-entry queue that drives the outputs. Throughput is one word per cycle
// while the receiver takes records.
// When the receiver stalls, the queue fills and data_stall rises once it
// holds two records; a stalled record holds still.
// Synchronous reset clears the queue, the window and the parse state and
// restores the register defaults. No clearing pass is needed.
// Consumers drop a packet's samples when its end record reports an error.
module fee_packet_parser
  import fpp_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data,
  input  logic        data_valid,
  output logic        data_stall,
  input  logic [15:0] data_word,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        record_kind,
  output logic [7:0]  fee,
  output logic [8:0]  channel,
  output logic [3:0]  chip_addr,
  output logic [4:0]  chip_chan,
  output logic [19:0] crossing_time,
  output logic [10:0] time_bin,
  output logic [15:0] adc_value,
  output logic [1:0]  status
);

  logic [15:0] magic_one, magic_two;
  logic [3:0]  header_words;
  logic [7:0]  fee_number;
  logic        room, in_beat, rec_valid;
  rec_t        rec, q_rec;

  always_ff @(posedge clk) begin
    if (rst) begin
      magic_one <= 16'h00fe;
      magic_two <= 16'h00ed;
      header_words <= 4'd7;
      fee_number <= 8'd0;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_MAGIC_ONE: magic_one <= cfg_data;
        REG_MAGIC_TWO: magic_two <= cfg_data;
        REG_HEADER:    header_words <= cfg_data[3:0];
        REG_FEE:       fee_number <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  assign data_stall = !room;
  assign in_beat = data_valid && room;

  fpp_front u_front (
    .clk, .rst, .in_beat, .word(data_word), .magic_one, .magic_two,
    .header_words, .rec_valid, .rec
  );

  fpp_queue u_queue (
    .clk, .rst, .push(rec_valid), .push_rec(rec), .room,
    .pop_valid(out_valid), .pop_rec(q_rec), .pop(out_valid && !out_stall)
  );

  assign record_kind   = q_rec.kind;
  assign fee           = fee_number;
  assign channel       = q_rec.channel;
  assign chip_addr     = q_rec.channel[8:5];
  assign chip_chan     = q_rec.channel[4:0];
  assign crossing_time = q_rec.crossing_time;
  assign time_bin      = q_rec.time_bin;
  assign adc_value     = q_rec.adc_value;
  assign status        = q_rec.status;

endmodule

/* tb/sv/tb_fee_packet_parser.sv */
// Self-checking testbench of the front-end packet parser: framed and noisy word streams.
`timescale 1ns / 100ps
module tb_fee_packet_parser;
  import fpp_pkg::*;

  typedef struct {
    logic        kind;
    logic [7:0]  fee;
    logic [8:0]  channel;
    logic [19:0] crossing_time;
    logic [10:0] time_bin;
    logic [15:0] adc_value;
    logic [1:0]  status;
  } parsed_rec_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_write = 1'b0;
  logic [1:0]  cfg_index = REG_MAGIC_ONE;
  logic [15:0] cfg_data = 16'd0;
  logic        data_valid = 1'b0;
  logic        data_stall;
  logic [15:0] data_word = 16'd0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        record_kind;
  logic [7:0]  fee;
  logic [8:0]  channel;
  logic [3:0]  chip_addr;
  logic [4:0]  chip_chan;
  logic [19:0] crossing_time;
  logic [10:0] time_bin;
  logic [15:0] adc_value;
  logic [1:0]  status;

  fee_packet_parser dut (.*);

  always #5 clk = ~clk;

  // predictor state
  logic [15:0] key_one, key_two;
  logic [3:0]  hdr_reg;
  logic [7:0]  fee_reg;
  logic [15:0] win [3];
  int unsigned win_fill;
  phase_t      phase;
  int unsigned pos, plen, left;
  logic [15:0] crc_acc;
  logic [8:0]  hdr_chan;
  logic [19:0] hdr_time;
  logic [10:0] tbin;
  logic        err_seen;

  parsed_rec_t expected_recs[$];
  logic [15:0] word_queue[$];
  int          errors = 0;
  int          n_samples = 0, n_ends = 0, n_bad = 0;
  longint      cycles = 0;
  int          hold_cycles = 0;
  int          send_gap = 0, recv_gap = 0;
  bit          pause_sender = 1'b0;

  function automatic logic [15:0] crc_step(logic [15:0] c, logic [15:0] w);
    logic [15:0] r;
    r = c ^ w;
    repeat (16) r = r[15] ? ({r[14:0], 1'b0} ^ 16'h8005) : {r[14:0], 1'b0};
    return r;
  endfunction

  task automatic push_rec(logic k, logic [8:0] ch, logic [19:0] ct, logic [10:0] tb,
                          logic [15:0] adc, logic [1:0] st);
    parsed_rec_t r;
    r.kind = k; r.fee = fee_reg; r.channel = ch; r.crossing_time = ct;
    r.time_bin = tb; r.adc_value = adc; r.status = st;
    expected_recs.insert(expected_recs.size(), r);
  endtask

  task automatic predict_word(logic [15:0] w);
    int unsigned hl, len;
    logic [1:0]  st;
    hl = (hdr_reg < MIN_HEADER) ? MIN_HEADER : hdr_reg;
    if (phase == PH_HUNT) begin
      if (win_fill >= 3) begin
        win[0] = win[1]; win[1] = win[2]; win[2] = w;
      end else begin
        win[win_fill] = w; win_fill++;
      end
      if (win_fill == 3 && win[1] == key_one && win[2] == key_two) begin
        len = win[0];
        if (len < hl) begin
          push_rec(1'b1, 9'd0, 20'd0, 11'd0, 16'd0, ST_FORMAT);
          win[0] = win[1]; win[1] = win[2]; win[2] = 16'd0; win_fill = 2;
        end else begin
          plen = len;
          crc_acc = crc_step(crc_step(crc_step(CRC_INIT, win[0]), win[1]), win[2]);
          pos = 3; hdr_chan = '0; hdr_time = '0; err_seen = 1'b0; left = 0; tbin = '0;
          phase = PH_HEADER; win_fill = 0;
        end
      end
      return;
    end
    if (pos == 4) hdr_chan = w[8:0];
    else if (pos == 5) hdr_time[9:0] = w[9:0];
    else if (pos == 6) hdr_time[19:10] = w[9:0];
    if (pos + 1 >= plen) begin
      if (crc_acc != w) st = ST_CRC;
      else if (err_seen || phase == PH_COUNT || phase == PH_START) st = ST_FORMAT;
      else st = ST_OK;
      push_rec(1'b1, hdr_chan, hdr_time, 11'd0, 16'd0, st);
      phase = PH_HUNT; win_fill = 0; pos = 0;
      return;
    end
    crc_acc = crc_step(crc_acc, w);
    case (phase)
      PH_HEADER: if (pos + 1 >= hl) phase = PH_COUNT;
      PH_COUNT: begin
        left = w; phase = PH_START;
      end
      PH_START: begin
        if (pos + 1 + left >= plen) begin
          err_seen = 1'b1; phase = PH_SKIP;
        end else if (left == 0) begin
          phase = (pos + 2 == plen) ? PH_SKIP : PH_COUNT;
        end else begin
          tbin = w[10:0]; phase = PH_SAMPLES;
        end
      end
      PH_SAMPLES: begin
        push_rec(1'b0, hdr_chan, hdr_time, tbin, w, ST_OK);
        left = (left - 1) & 16'hffff; tbin = tbin + 11'd1;
        if (pos + 2 == plen) phase = PH_SKIP;
        else if (left == 0) phase = PH_COUNT;
      end
      default: ;
    endcase
    pos = pos + 1;
  endtask

  // packet builder: mode 0 good, 1 bad CRC, 2 overrun, 3 ends in group header
  task automatic build_packet(int mode, int unsigned hl, int max_groups, int max_n);
    logic [15:0] pk[$];
    logic [15:0] c;
    int          ng, n;
    ng = $urandom_range(0, max_groups);
    pk.insert(pk.size(), 16'd0); pk.insert(pk.size(), key_one);
    pk.insert(pk.size(), key_two);
    while (pk.size() < hl) pk.insert(pk.size(), 16'($urandom));
    for (int g = 0; g < ng; g++) begin
      n = $urandom_range(0, max_n);
      pk.insert(pk.size(), 16'(n)); pk.insert(pk.size(), 16'($urandom));
      for (int s = 0; s < n; s++) pk.insert(pk.size(), 16'($urandom));
    end
    if (mode == 2) begin
      pk.insert(pk.size(), 16'($urandom_range(40, 65535)));
      pk.insert(pk.size(), 16'($urandom));
      pk.insert(pk.size(), 16'($urandom));
    end else if (mode == 3) begin
      pk.insert(pk.size(), 16'($urandom_range(0, 3)));
    end
    pk[0] = 16'(pk.size() + 1);
    c = CRC_INIT;
    foreach (pk[i]) c = crc_step(c, pk[i]);
    if (mode == 1) c = c ^ 16'(1 << $urandom_range(0, 15));
    pk.insert(pk.size(), c);
    foreach (pk[i]) word_queue.insert(word_queue.size(), pk[i]);
  endtask

  task automatic wait_drained();
    while (word_queue.size() != 0 || data_valid) @(posedge clk);
    while (expected_recs.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [15:0] val);
    cfg_write <= 1'b1; cfg_index <= idx; cfg_data <= val;
    @(posedge clk);
    cfg_write <= 1'b0;
    case (idx)
      REG_MAGIC_ONE: key_one = val;
      REG_MAGIC_TWO: key_two = val;
      REG_HEADER:    hdr_reg = val[3:0];
      default:       fee_reg = val[7:0];
    endcase
    @(posedge clk);
  endtask

  // driver
  always @(posedge clk) begin
    if (rst) begin
      data_valid <= 1'b0;
    end else if (data_valid && !data_stall) begin
      predict_word(data_word);
      send_gap = $urandom_range(0, 3) * ($urandom_range(0, 3) == 0);
      if (send_gap == 0 && word_queue.size() != 0 && !pause_sender) begin
        data_word <= word_queue[0];
        word_queue.delete(0);
      end else begin
        data_valid <= 1'b0;
      end
    end else if (!data_valid) begin
      if (send_gap > 0) begin
        send_gap--;
      end else if (word_queue.size() != 0 && !pause_sender) begin
        data_valid <= 1'b1;
        data_word <= word_queue[0];
        word_queue.delete(0);
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    parsed_rec_t e;
    cycles++;
    if (cycles > 400000) begin
      $display("CHECK FAILED");
      $finish;
    end
    if (!rst && out_valid && !out_stall) begin
      if (expected_recs.size() == 0) begin
        $error("record with none expected");
        errors++;
      end else begin
        e = expected_recs[0];
        expected_recs.delete(0);
        if (record_kind !== e.kind) begin
          $error("record_kind exp %0d got %0d", e.kind, record_kind); errors++;
        end
        if (fee !== e.fee) begin
          $error("fee exp %0d got %0d", e.fee, fee); errors++;
        end
        if (channel !== e.channel) begin
          $error("channel exp %0d got %0d", e.channel, channel); errors++;
        end
        if (chip_addr !== e.channel[8:5]) begin
          $error("chip_addr exp %0d got %0d", e.channel[8:5], chip_addr); errors++;
        end
        if (chip_chan !== e.channel[4:0]) begin
          $error("chip_chan exp %0d got %0d", e.channel[4:0], chip_chan); errors++;
        end
        if (crossing_time !== e.crossing_time) begin
          $error("crossing_time exp %0d got %0d", e.crossing_time, crossing_time); errors++;
        end
        if (time_bin !== e.time_bin) begin
          $error("time_bin exp %0d got %0d", e.time_bin, time_bin); errors++;
        end
        if (adc_value !== e.adc_value) begin
          $error("adc_value exp %0d got %0d", e.adc_value, adc_value); errors++;
        end
        if (status !== e.status) begin
          $error("status exp %0d got %0d", e.status, status); errors++;
        end
        if (e.kind) begin
          n_ends++;
          if (e.status != ST_OK) n_bad++;
        end else begin
          n_samples++;
        end
      end
    end
    if (hold_cycles > 0) begin
      hold_cycles--;
      out_stall <= 1'b1;
    end else if (out_stall) begin
      out_stall <= (recv_gap > 0);
      if (recv_gap > 0) recv_gap--;
    end else if (out_valid) begin
      recv_gap = $urandom_range(0, 3) * ($urandom_range(0, 2) == 0);
      out_stall <= (recv_gap > 0);
      if (recv_gap > 0) recv_gap--;
    end
  end

  initial begin
    logic [15:0] v;
    key_one = 16'd254; key_two = 16'd237; hdr_reg = 4'd7; fee_reg = 8'd0;
    win_fill = 0; phase = PH_HUNT; pos = 0; plen = 0; left = 0;
    crc_acc = CRC_INIT; hdr_chan = '0; hdr_time = '0; tbin = '0; err_seen = 1'b0;
    foreach (win[i]) win[i] = '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: one of each packet kind, short length, extreme words
    build_packet(0, 7, 2, 3);
    build_packet(1, 7, 1, 2);
    build_packet(2, 7, 1, 1);
    build_packet(3, 7, 1, 1);
    word_queue.insert(word_queue.size(), 16'd3);
    word_queue.insert(word_queue.size(), key_one);
    word_queue.insert(word_queue.size(), key_two);
    word_queue.insert(word_queue.size(), 16'hffff);
    word_queue.insert(word_queue.size(), 16'h0000);
    wait_drained();

    for (int ph = 0; ph < 6; ph++) begin
      write_reg(REG_MAGIC_ONE, (ph == 1) ? 16'hffff : (ph == 2) ? 16'h0000 : 16'($urandom));
      write_reg(REG_MAGIC_TWO, (ph == 1) ? 16'h0000 : (ph == 2) ? 16'hffff : 16'($urandom));
      v = (ph == 1) ? 16'd15 : (ph == 2) ? 16'd0 : 16'($urandom_range(0, 15));
      write_reg(REG_HEADER, v);
      write_reg(REG_FEE, (ph == 1) ? 16'd255 : 16'($urandom_range(0, 255)));
      while (word_queue.size() < 300 * (ph + 1) / (ph + 1) && cycles < 390000) begin
        int unsigned hl;
        hl = (hdr_reg < MIN_HEADER) ? MIN_HEADER : hdr_reg;
        case ($urandom_range(0, 9))
          0: build_packet(1, hl, 3, 6);
          1: build_packet(2, hl, 2, 4);
          2: build_packet(3, hl, 2, 4);
          3: repeat ($urandom_range(1, 5)) word_queue.insert(word_queue.size(), 16'($urandom));
          4: begin
            word_queue.insert(word_queue.size(), 16'($urandom_range(0, hl - 1)));
            word_queue.insert(word_queue.size(), key_one);
            word_queue.insert(word_queue.size(), key_two);
          end
          default: build_packet(0, hl, 4, 8);
        endcase
      end
      if (ph == 3) begin
        hold_cycles = 60;
      end
      if (ph == 4) begin
        while (word_queue.size() > 150) @(posedge clk);
        pause_sender = 1'b1;
        while (expected_recs.size() != 0 || data_valid) @(posedge clk);
        pause_sender = 1'b0;
      end
      wait_drained();
    end

    $display("Covered %0d sample records and %0d end records, %0d with error status.",
             n_samples, n_ends, n_bad);
    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

/* filelist.f */
design/fpp_pkg.sv
design/fpp_front.sv
design/fpp_queue.sv
design/fee_packet_parser.sv
tb/sv/tb_fee_packet_parser.sv
